[hdl/last_note_priority_key_tracker_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the last-note priority key tracker
// Shared property wrappers, sampled on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef LAST_NOTE_PRIORITY_KEY_TRACKER_ASSERT_SVH
`define LAST_NOTE_PRIORITY_KEY_TRACKER_ASSERT_SVH

// same-cycle implication
`define LNPK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lnpk assertion failed");

// next-cycle implication
`define LNPK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lnpk assertion failed");

`endif

[hdl/lnpk_pkg.sv]
// ----------------------------------------------------------------------------
// lnpk_pkg
// Types, codes and defaults for the last-note priority key tracker.
// ----------------------------------------------------------------------------
package lnpk_pkg;

  localparam int CHANNELS_DEF  = 16;
  localparam int NOTES_DEF     = 128;
  localparam int HOLD_BITS_DEF = 16;

  // key = {channel, note}; bit 11 set means no key
  localparam int KEY_W  = 11;
  localparam int KEYS   = 1 << KEY_W;
  localparam logic [11:0] KEY_NONE = 12'hFFF;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SHOT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLIDE    = 1'd1;

  // input opcodes
  localparam logic [2:0] OP_NOTE_ON   = 3'd0;
  localparam logic [2:0] OP_NOTE_OFF  = 3'd1;
  localparam logic [2:0] OP_ALL_NOTES = 3'd2;
  localparam logic [2:0] OP_ALL_SOUND = 3'd3;
  localparam logic [2:0] OP_SILENT    = 3'd4;

  // classified commands
  localparam logic [2:0] CMD_NOP = 3'd0;
  localparam logic [2:0] CMD_ON  = 3'd1;
  localparam logic [2:0] CMD_OFF = 3'd2;
  localparam logic [2:0] CMD_ANO = 3'd3;
  localparam logic [2:0] CMD_ASO = 3'd4;
  localparam logic [2:0] CMD_SIL = 3'd5;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] channel_index;
    logic [6:0] note_number;
    logic [6:0] note_velocity;
  } in_word_t;

  typedef struct packed {
    logic        voice_active;
    logic        key_valid;
    logic [3:0]  voice_channel;
    logic [6:0]  voice_note;
    logic        gate_released;
    logic        retrigger;
    logic        legato_slide;
    logic        pitch_jump;
    logic [6:0]  latched_velocity;
    logic [11:0] held_total;
  } out_word_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] ch;
    logic [6:0] note;
    logic [6:0] vel;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic init_done;
  } back_stat_t;

endpackage

[hdl/lnpk_front.sv]
// ----------------------------------------------------------------------------
// lnpk_front
// Accepts event words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module lnpk_front import lnpk_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int NOTES    = NOTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_word_t   in_word,
  input  back_stat_t stat,
  output logic       q_valid,
  output cmd_t       q_head
);

  cmd_t       q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       ch_ok, key_ok;
  cmd_t       cls;

  assign busy    = (cnt_r == 2'd2) || !stat.init_done;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = q_mem[rd_ptr_r];

  always_comb begin
    ch_ok  = {1'b0, in_word.channel_index} < 5'(CHANNELS);
    key_ok = ch_ok && ({1'b0, in_word.note_number} < 8'(NOTES));
    cls.ch   = in_word.channel_index;
    cls.note = in_word.note_number;
    cls.vel  = in_word.note_velocity;
    case (in_word.opcode)
      OP_NOTE_ON:   cls.cmd = key_ok ? CMD_ON : CMD_NOP;
      OP_NOTE_OFF:  cls.cmd = key_ok ? CMD_OFF : CMD_NOP;
      OP_ALL_NOTES: cls.cmd = ch_ok ? CMD_ANO : CMD_NOP;
      OP_ALL_SOUND: cls.cmd = ch_ok ? CMD_ASO : CMD_NOP;
      OP_SILENT:    cls.cmd = CMD_SIL;
      default:      cls.cmd = CMD_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = stat.pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(stat.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

endmodule

[hdl/lnpk_back.sv]
// ----------------------------------------------------------------------------
// lnpk_back
// Key store sequencer: hold counts, held-key list and voice state.
// ----------------------------------------------------------------------------
module lnpk_back import lnpk_pkg::*; #(
  parameter int NOTES     = NOTES_DEF,
  parameter int HOLD_BITS = HOLD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  cmd_t                 q_head,
  output back_stat_t           stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,
  output logic                 out_valid,
  output out_word_t            out_word
);

  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_RD   = 4'd2;
  localparam logic [3:0] ST_LINK = 4'd3;
  localparam logic [3:0] ST_KCLR = 4'd4;
  localparam logic [3:0] ST_APP  = 4'd5;
  localparam logic [3:0] ST_APP2 = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;

  localparam logic [HOLD_BITS-1:0] HOLD_MAX = '1;

  logic [HOLD_BITS-1:0] hold_mem [KEYS];
  logic [11:0]          prev_mem [KEYS];
  logic [11:0]          next_mem [KEYS];

  logic [HOLD_BITS-1:0] hold_rd_r;
  logic [11:0]          prev_rd_r, next_rd_r;

  logic                 hold_we, prev_we, next_we;
  logic [KEY_W-1:0]     hold_wa, prev_wa, next_wa;
  logic [HOLD_BITS-1:0] hold_wd;
  logic [11:0]          prev_wd, next_wd;

  logic [3:0]       state_r, state_nxt;
  logic [KEY_W-1:0] init_r, init_nxt;
  logic [KEY_W-1:0] k_r, k_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic             legato_r, legato_nxt;
  logic             jump_r, jump_nxt;
  logic             owns_r, owns_nxt;
  logic             hit_r, hit_nxt;
  logic [11:0]      oldest_r, oldest_nxt;
  logic [11:0]      newest_r, newest_nxt;
  logic [11:0]      total_r, total_nxt;
  logic [11:0]      cur_r, cur_nxt;
  logic             active_r, active_nxt;
  logic             rel_r, rel_nxt;
  logic [6:0]       vel_r, vel_nxt;
  logic             one_shot_r, glide_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic             in_list, last_note, can_hand;
  logic [11:0]      k_key;

  assign stat.init_done = (state_r != ST_INIT);
  assign stat.pop       = (state_r == ST_IDLE) && q_valid;
  assign out_valid      = out_valid_r;
  assign out_word       = out_word_r;

  always_comb begin
    k_key     = {1'b0, k_r};
    in_list   = !prev_rd_r[11] || !next_rd_r[11] || (oldest_r == k_key);
    last_note = (k_r[6:0] == 7'(NOTES - 1));
    can_hand  = (total_r != 12'd0) && !newest_r[11];

    state_nxt  = state_r;
    init_nxt   = init_r;
    k_nxt      = k_r;
    cmd_nxt    = cmd_r;
    legato_nxt = legato_r;
    jump_nxt   = jump_r;
    owns_nxt   = owns_r;
    hit_nxt    = hit_r;
    oldest_nxt = oldest_r;
    newest_nxt = newest_r;
    total_nxt  = total_r;
    cur_nxt    = cur_r;
    active_nxt = active_r;
    rel_nxt    = rel_r;
    vel_nxt    = vel_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;

    hold_we = 1'b0; hold_wa = k_r; hold_wd = '0;
    prev_we = 1'b0; prev_wa = k_r; prev_wd = KEY_NONE;
    next_we = 1'b0; next_wa = k_r; next_wd = KEY_NONE;

    case (state_r)
      ST_INIT: begin
        hold_we = 1'b1; prev_we = 1'b1; next_we = 1'b1;
        hold_wa = init_r; prev_wa = init_r; next_wa = init_r;
        init_nxt = init_r + 1'b1;
        if (init_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          cmd_nxt = q_head;
          hit_nxt = 1'b0;
          legato_nxt = active_r && (total_r != 12'd0) &&
                       (cur_r[11] || (q_head.note != cur_r[6:0])) && glide_r;
          jump_nxt   = !active_r || !glide_r;
          owns_nxt   = !cur_r[11] && (cur_r[10:7] == q_head.ch);
          case (q_head.cmd)
            CMD_ON, CMD_OFF: begin
              k_nxt = {q_head.ch, q_head.note};
              state_nxt = ST_RD;
            end
            CMD_ANO, CMD_ASO: begin
              k_nxt = {q_head.ch, 7'd0};
              state_nxt = ST_RD;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_RD: begin
        if (cmd_r.cmd == CMD_ANO || cmd_r.cmd == CMD_ASO) begin
          hold_we = 1'b1;
        end
        state_nxt = ST_LINK;
      end
      ST_LINK: begin
        case (cmd_r.cmd)
          CMD_ON: begin
            hold_we = 1'b1;
            hold_wd = (hold_rd_r != HOLD_MAX) ? hold_rd_r + 1'b1 : hold_rd_r;
            state_nxt = ST_APP;
          end
          CMD_OFF: begin
            state_nxt = ST_FIN;
            if (hold_rd_r != '0) begin
              hold_we = 1'b1;
              hold_wd = hold_rd_r - 1'b1;
              if (hold_rd_r == HOLD_BITS'(1)) begin
                hit_nxt = 1'b1;
                if (in_list) begin
                  state_nxt = ST_KCLR;
                end
              end
            end
          end
          default: begin
            if (in_list) begin
              state_nxt = ST_KCLR;
            end else if (last_note) begin
              state_nxt = ST_FIN;
            end else begin
              k_nxt = k_r + 1'b1;
              state_nxt = ST_RD;
            end
          end
        endcase
        // unlink k from the held list
        if (in_list && (cmd_r.cmd == CMD_ON || cmd_r.cmd == CMD_ANO ||
            cmd_r.cmd == CMD_ASO || (cmd_r.cmd == CMD_OFF &&
            hold_rd_r == HOLD_BITS'(1)))) begin
          if (!prev_rd_r[11]) begin
            next_we = 1'b1;
            next_wa = prev_rd_r[KEY_W-1:0];
            next_wd = next_rd_r;
          end else begin
            oldest_nxt = next_rd_r;
          end
          if (!next_rd_r[11]) begin
            prev_we = 1'b1;
            prev_wa = next_rd_r[KEY_W-1:0];
            prev_wd = prev_rd_r;
          end else begin
            newest_nxt = prev_rd_r;
          end
          if (total_r != 12'd0) begin
            total_nxt = total_r - 12'd1;
          end
        end
      end
      ST_KCLR: begin
        prev_we = 1'b1;
        next_we = 1'b1;
        if (cmd_r.cmd == CMD_OFF || last_note) begin
          state_nxt = ST_FIN;
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_APP: begin
        prev_we = 1'b1;
        prev_wd = newest_r;
        next_we = 1'b1;
        state_nxt = ST_APP2;
      end
      ST_APP2: begin
        if (!newest_r[11]) begin
          next_we = 1'b1;
          next_wa = newest_r[KEY_W-1:0];
          next_wd = k_key;
        end else begin
          oldest_nxt = k_key;
        end
        newest_nxt = k_key;
        total_nxt  = total_r + 12'd1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        out_word_nxt.retrigger    = 1'b0;
        out_word_nxt.legato_slide = 1'b0;
        out_word_nxt.pitch_jump   = 1'b0;
        case (cmd_r.cmd)
          CMD_ON: begin
            cur_nxt = k_key;
            rel_nxt = 1'b0;
            out_word_nxt.pitch_jump = jump_r;
            if (legato_r) begin
              out_word_nxt.legato_slide = 1'b1;
            end else begin
              vel_nxt = cmd_r.vel;
              active_nxt = 1'b1;
              out_word_nxt.retrigger = 1'b1;
            end
          end
          CMD_OFF, CMD_ANO: begin
            if (!one_shot_r && ((cmd_r.cmd == CMD_OFF && hit_r && cur_r == k_key) ||
                (cmd_r.cmd == CMD_ANO && owns_r))) begin
              if (can_hand) begin
                cur_nxt = newest_r;
                rel_nxt = 1'b0;
              end else begin
                rel_nxt = 1'b1;
              end
            end
          end
          CMD_ASO: begin
            if (owns_r) begin
              rel_nxt = 1'b0;
              if (can_hand) begin
                cur_nxt = newest_r;
              end else begin
                active_nxt = 1'b0;
                cur_nxt = KEY_NONE;
              end
            end
          end
          CMD_SIL: begin
            active_nxt = 1'b0;
            cur_nxt = KEY_NONE;
          end
          default: begin
          end
        endcase
        out_valid_nxt = 1'b1;
        out_word_nxt.voice_active     = active_nxt;
        out_word_nxt.key_valid        = !cur_nxt[11];
        out_word_nxt.voice_channel    = cur_nxt[11] ? 4'd0 : cur_nxt[10:7];
        out_word_nxt.voice_note       = cur_nxt[11] ? 7'd0 : cur_nxt[6:0];
        out_word_nxt.gate_released    = rel_nxt;
        out_word_nxt.latched_velocity = vel_nxt;
        out_word_nxt.held_total       = total_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_r      <= '0;
      oldest_r    <= KEY_NONE;
      newest_r    <= KEY_NONE;
      total_r     <= 12'd0;
      cur_r       <= KEY_NONE;
      active_r    <= 1'b0;
      rel_r       <= 1'b0;
      vel_r       <= 7'd0;
      one_shot_r  <= 1'b1;
      glide_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      oldest_r    <= oldest_nxt;
      newest_r    <= newest_nxt;
      total_r     <= total_nxt;
      cur_r       <= cur_nxt;
      active_r    <= active_nxt;
      rel_r       <= rel_nxt;
      vel_r       <= vel_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_ONE_SHOT) begin
        one_shot_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_GLIDE) begin
        glide_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    cmd_r      <= cmd_nxt;
    legato_r   <= legato_nxt;
    jump_r     <= jump_nxt;
    owns_r     <= owns_nxt;
    hit_r      <= hit_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (hold_we) begin
      hold_mem[hold_wa] <= hold_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    hold_rd_r <= hold_mem[k_r];
    prev_rd_r <= prev_mem[k_r];
    next_rd_r <= next_mem[k_r];
  end

endmodule

[hdl/last_note_priority_key_tracker.sv]
// ----------------------------------------------------------------------------
// last_note_priority_key_tracker
// Monophonic last-note priority voice allocator over channels x notes.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 2048-entry key store with busy high. An
// event word is taken when start is high and busy is low; a two-word queue
// lets the next events wait while one is worked. A channel clear visits the
// notes of the channel one at a time, as each key store memory has a single
// read and write port. Each event gives one result on out_word, marked by
// out_valid for one cycle; the receiver cannot stall it.
module last_note_priority_key_tracker import lnpk_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int NOTES     = NOTES_DEF,
  parameter int HOLD_BITS = HOLD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             in_word,
  output logic                 out_valid,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata
);

  back_stat_t stat;
  logic       q_valid;
  cmd_t       q_head;

  lnpk_front #(
    .CHANNELS(CHANNELS),
    .NOTES   (NOTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_word(in_word),
    .stat   (stat),
    .q_valid(q_valid),
    .q_head (q_head)
  );

  lnpk_back #(
    .NOTES    (NOTES),
    .HOLD_BITS(HOLD_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .stat     (stat),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_word (out_word)
  );

endmodule

[hdl/lnpk_checker.sv]
// ----------------------------------------------------------------------------
// lnpk_checker
// Port-level checks on the result words of the key tracker.
// ----------------------------------------------------------------------------
`include "last_note_priority_key_tracker_assert.svh"

module lnpk_checker import lnpk_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input out_word_t out_word
);

  `LNPK_ASSERT_NXT(a_strobe_gap, out_valid, !out_valid)
  `LNPK_ASSERT_IMP(a_no_key_zero, out_valid && !out_word.key_valid, out_word.voice_channel == 4'd0 && out_word.voice_note == 7'd0)
  `LNPK_ASSERT_IMP(a_retrig_sounds, out_valid && out_word.retrigger, out_word.voice_active && out_word.key_valid && !out_word.gate_released && !out_word.legato_slide)
  `LNPK_ASSERT_IMP(a_slide_sounds, out_valid && out_word.legato_slide, out_word.voice_active && out_word.key_valid)

endmodule

bind last_note_priority_key_tracker lnpk_checker u_lnpk_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_word (out_word)
);
